// ===== rtl/shuffle_permutation_generator_core_defines.svh =====
// Assertion helpers shared by the permutation generator RTL.
`ifndef SHUFFLE_PERMUTATION_GENERATOR_CORE_DEFINES_SVH
`define SHUFFLE_PERMUTATION_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spg_pkg.sv =====
`default_nettype none

package spg_pkg;

    // Field widths of the stream and register payloads.
    localparam int DRAW_W  = 10;
    localparam int ELEM_W  = 10;
    localparam int CFG_W   = 11;
    localparam int TDATA_W = 16;
    localparam int TUSER_W = 2;

    // Bit positions of the flags in the output tuser.
    localparam int USER_IS_ONE    = 0;
    localparam int USER_RANGE_ERR = 1;

    // Register port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_PERM_LENGTH = 1'b0;
    localparam logic REG_IDX_ONES_COUNT  = 1'b1;
    localparam logic [CFG_W-1:0] PERM_LENGTH_RST = 11'd1024;
    localparam logic [CFG_W-1:0] ONES_COUNT_RST  = 11'd0;

    // Round tag stored beside each pool entry; a wrap forces a clearing sweep.
    localparam int EPOCH_W = 8;

    // Sweep request from the front end to the back end.
    typedef struct packed {
        logic req;
    } t_sweep_ctl;

    // Sweep status from the back end.
    typedef struct packed {
        logic active;
        logic done;
    } t_sweep_stat;

endpackage

`default_nettype wire

// ===== rtl/spg_queue.sv =====
`default_nettype none

module spg_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spg_front.sv =====
`default_nettype none

module spg_front #(
    parameter int MAX_LENGTH = 1024,
    localparam int IW = $clog2(MAX_LENGTH),
    localparam int ITEM_W = 2 * IW + spg_pkg::EPOCH_W + 2
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Register port
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic [spg_pkg::APB_ADDR_W-1:0] i_paddr,
    input  wire logic [spg_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [spg_pkg::APB_DATA_W-1:0]      o_prdata,
    // Draw requests
    input  wire logic                           i_tvalid,
    output logic                                o_tready,
    input  wire logic [spg_pkg::TDATA_W-1:0]    i_tdata,
    // Queue toward the back end
    output logic                                o_push,
    output logic [ITEM_W-1:0]                   o_item,
    input  wire logic                           i_q_full,
    // Sweep control and shared settings
    output spg_pkg::t_sweep_ctl                 o_sweep,
    input  wire spg_pkg::t_sweep_stat           i_sweep,
    output logic [spg_pkg::CFG_W-1:0]           o_ones
);

    import spg_pkg::*;

    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;
    localparam int XW = (CW > DRAW_W) ? CW : DRAW_W;

    logic [CFG_W-1:0]   r_perm_len;
    logic [CFG_W-1:0]   r_ones;
    logic [CW-1:0]      r_remain;
    logic [EPOCH_W-1:0] r_epoch;

    logic               cfg_wr;
    logic               fresh;
    logic               need_sweep;
    logic               accept;
    logic               in_range;
    logic [LW-1:0]      pl_x;
    logic [LW-1:0]      eff_x;
    logic [CW-1:0]      count;
    logic [CW-1:0]      last;
    logic [XW-1:0]      idx_x;
    logic [EPOCH_W-1:0] epoch_use;
    logic               last_of_round;

    // Register writes and reads; the address selects by its word bit.
    assign cfg_wr = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_len <= PERM_LENGTH_RST;
            r_ones     <= ONES_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (i_paddr[2])
                REG_IDX_PERM_LENGTH: r_perm_len <= i_pwdata[CFG_W-1:0];
                REG_IDX_ONES_COUNT:  r_ones     <= i_pwdata[CFG_W-1:0];
                default:             r_ones     <= r_ones;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_IDX_PERM_LENGTH: o_prdata = APB_DATA_W'(r_perm_len);
            REG_IDX_ONES_COUNT:  o_prdata = APB_DATA_W'(r_ones);
            default:             o_prdata = '0;
        endcase
    end

    assign o_ones = r_ones;

    // Round length, clamped to the supported range.
    assign pl_x  = LW'(r_perm_len);
    assign eff_x = (pl_x == '0) ? LW'(1) :
                   (pl_x > LW'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : pl_x;

    // Classify the incoming draw against the remaining pool.
    assign fresh      = (r_remain == '0);
    assign count      = fresh ? CW'(eff_x) : r_remain;
    assign last       = count - CW'(1);
    assign idx_x      = XW'(i_tdata[DRAW_W-1:0]);
    assign in_range   = idx_x < XW'(count);
    assign epoch_use  = fresh ? (r_epoch + EPOCH_W'(1)) : r_epoch;
    assign last_of_round = in_range && (last == '0);

    // A new round cannot start on an exhausted tag; wait for the sweep.
    assign need_sweep  = fresh && (r_epoch == '1);
    assign o_sweep.req = need_sweep;

    assign o_tready = !need_sweep && !i_q_full;
    assign accept   = i_tvalid && o_tready;
    assign o_push   = accept;
    assign o_item   = {epoch_use, !in_range, last_of_round, last[IW-1:0], idx_x[IW-1:0]};

    // Pool count and round tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= '0;
            r_epoch  <= '1;
        end else begin
            if (accept && in_range) begin
                r_remain <= last;
                if (fresh) begin
                    r_epoch <= epoch_use;
                end
            end else if (i_sweep.done) begin
                r_epoch <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spg_back.sv =====
`default_nettype none

module spg_back #(
    parameter int MAX_LENGTH = 1024,
    localparam int IW = $clog2(MAX_LENGTH),
    localparam int ITEM_W = 2 * IW + spg_pkg::EPOCH_W + 2
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Queue from the front end
    input  wire logic                        i_q_valid,
    input  wire logic [ITEM_W-1:0]           i_q_data,
    output logic                             o_pop,
    // Sweep control and shared settings
    input  wire spg_pkg::t_sweep_ctl         i_sweep,
    output spg_pkg::t_sweep_stat             o_sweep,
    input  wire logic [spg_pkg::CFG_W-1:0]   i_ones,
    // Result stream
    output logic                             o_tvalid,
    input  wire logic                        i_tready,
    output logic [spg_pkg::TDATA_W-1:0]      o_tdata,
    output logic [spg_pkg::TUSER_W-1:0]      o_tuser,
    output logic                             o_tlast
);

    import spg_pkg::*;

    localparam int ENT_W = EPOCH_W + IW;
    localparam int PW    = (IW > CFG_W) ? IW : CFG_W;

    // Pool memory: each entry is {round tag, value}.
    logic [ENT_W-1:0] r_mem [MAX_LENGTH];
    logic [ENT_W-1:0] r_rd_a;
    logic [ENT_W-1:0] r_rd_b;

    // Execute stage.
    logic               r_e_valid;
    logic [IW-1:0]      r_e_idx;
    logic [IW-1:0]      r_e_last;
    logic [EPOCH_W-1:0] r_e_epoch;
    logic               r_e_err;
    logic               r_e_lor;

    // Write that landed at the same edge as the execute stage's read.
    logic               r_fw_valid;
    logic [IW-1:0]      r_fw_addr;
    logic [ENT_W-1:0]   r_fw_data;

    // Output register.
    logic               r_o_valid;
    logic [ELEM_W-1:0]  r_o_elem;
    logic               r_o_one;
    logic               r_o_lor;
    logic               r_o_err;

    // Sweep sequencer.
    logic               r_sw_active;
    logic               r_sw_done;
    logic [IW-1:0]      r_sw_addr;

    logic [IW-1:0]      q_idx;
    logic [IW-1:0]      q_last;
    logic               o_free;
    logic               e_fire;
    logic               advance;
    logic               sw_start;
    logic [ENT_W-1:0]   ent_a;
    logic [ENT_W-1:0]   ent_b;
    logic [IW-1:0]      pick;
    logic [IW-1:0]      move_val;
    logic [PW-1:0]      pick_x;
    logic               e_we;
    logic               mem_we;
    logic [IW-1:0]      mem_wa;
    logic [ENT_W-1:0]   mem_wd;

    assign q_idx  = i_q_data[IW-1:0];
    assign q_last = i_q_data[2*IW-1:IW];

    // Pipeline flow: execute fires into a free output register.
    assign o_free  = !r_o_valid || i_tready;
    assign e_fire  = r_e_valid && o_free;
    assign advance = !r_e_valid || o_free;
    assign o_pop   = advance && i_q_valid && !r_sw_active;

    // Resolve both slots, taking the newest write and the round tag into account.
    assign ent_a = (r_fw_valid && (r_fw_addr == r_e_idx)) ? r_fw_data : r_rd_a;
    assign ent_b = (r_fw_valid && (r_fw_addr == r_e_last)) ? r_fw_data : r_rd_b;
    assign pick     = (ent_a[ENT_W-1:IW] == r_e_epoch) ? ent_a[IW-1:0] : r_e_idx;
    assign move_val = (ent_b[ENT_W-1:IW] == r_e_epoch) ? ent_b[IW-1:0] : r_e_last;
    assign pick_x   = PW'(pick);

    // The last slot moves into the drawn slot unless they coincide.
    assign e_we = e_fire && !r_e_err && (r_e_idx != r_e_last);

    // Sweep starts once the back end has drained.
    assign sw_start = i_sweep.req && !r_e_valid && !i_q_valid && !r_sw_active && !r_sw_done;

    always_comb begin
        if (r_sw_active) begin
            mem_we = 1'b1;
            mem_wa = r_sw_addr;
            mem_wd = '0;
        end else begin
            mem_we = e_we;
            mem_wa = r_e_idx;
            mem_wd = {r_e_epoch, move_val};
        end
    end

    // Pool memory: one write, two registered reads.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (advance) begin
            r_rd_a <= r_mem[q_idx];
            r_rd_b <= r_mem[q_last];
        end
    end

    // Execute stage load and bypass capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
        end else if (advance) begin
            r_e_valid  <= o_pop;
            r_fw_valid <= e_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_e_idx   <= q_idx;
            r_e_last  <= q_last;
            r_e_lor   <= i_q_data[2*IW];
            r_e_err   <= i_q_data[2*IW+1];
            r_e_epoch <= i_q_data[ITEM_W-1:2*IW+2];
            r_fw_addr <= r_e_idx;
            r_fw_data <= {r_e_epoch, move_val};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (e_fire) begin
            r_o_valid <= 1'b1;
        end else if (i_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_fire) begin
            r_o_err  <= r_e_err;
            r_o_elem <= r_e_err ? '0 : pick_x[ELEM_W-1:0];
            r_o_one  <= !r_e_err && (pick_x < PW'(i_ones));
            r_o_lor  <= !r_e_err && r_e_lor;
        end
    end

    assign o_tvalid = r_o_valid;
    assign o_tdata  = TDATA_W'(r_o_elem);
    assign o_tlast  = r_o_lor;
    always_comb begin
        o_tuser = '0;
        o_tuser[USER_IS_ONE]    = r_o_one;
        o_tuser[USER_RANGE_ERR] = r_o_err;
    end

    // Clearing sweep: write a zero tag to every pool entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_active <= 1'b0;
            r_sw_done   <= 1'b0;
            r_sw_addr   <= '0;
        end else begin
            r_sw_done <= 1'b0;
            if (sw_start) begin
                r_sw_active <= 1'b1;
                r_sw_addr   <= '0;
            end else if (r_sw_active) begin
                if (r_sw_addr == IW'(MAX_LENGTH - 1)) begin
                    r_sw_active <= 1'b0;
                    r_sw_done   <= 1'b1;
                end else begin
                    r_sw_addr <= r_sw_addr + IW'(1);
                end
            end
        end
    end

    assign o_sweep.active = r_sw_active;
    assign o_sweep.done   = r_sw_done;

endmodule

`default_nettype wire

// ===== rtl/shuffle_permutation_generator_core.sv =====
// Random permutation generator (swap-free Fisher-Yates shuffle).
// Draw requests arrive on the s_axis channel: each carries a random index below
// the count of entries still left in the round. For every request one result
// leaves on m_axis: the drawn element, a combination flag (element below
// ones_count), tlast on the final element of a round, and a range flag when
// the index was too large (that request changes nothing). The APB port holds
// perm_length and ones_count; write them only while the block is idle.
// Throughput is one request per cycle unless the output stalls or a sweep runs,
// set by the pool memory's single write port and two read ports; each result is
// held in the execute stage, then in the output register. A two-entry queue
// parts the request classifier from the memory pipeline, and an output register
// lets a new request in while a result waits. When the receiver stalls, results
// fill the output register, the pipeline and the queue, and then s_axis_tready
// drops. After reset the pool's round tags are cleared in a sweep during which
// no request is taken; the same sweep runs again after every 255 rounds, once
// the last result of those rounds has left the pool.
`default_nettype none

module shuffle_permutation_generator_core #(
    parameter int MAX_LENGTH = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [spg_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [spg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spg_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // Draw requests
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [spg_pkg::TDATA_W-1:0]    s_axis_tdata,   // [9:0] draw_index
    // Results
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [spg_pkg::TDATA_W-1:0]         m_axis_tdata,   // [9:0] element
    output logic [spg_pkg::TUSER_W-1:0]         m_axis_tuser,   // [0] is_one, [1] range_error
    output logic                                m_axis_tlast    // last_of_round
);

    import spg_pkg::*;

`include "shuffle_permutation_generator_core_defines.svh"

    localparam int IW     = $clog2(MAX_LENGTH);
    localparam int ITEM_W = 2 * IW + EPOCH_W + 2;

    logic              q_push;
    logic [ITEM_W-1:0] q_in;
    logic              q_full;
    logic              q_valid;
    logic [ITEM_W-1:0] q_out;
    logic              q_pop;
    t_sweep_ctl        sweep_ctl;
    t_sweep_stat       sweep_stat;
    logic [CFG_W-1:0]  ones;

    assign pready = 1'b1;

    // Front end: registers and request classification.
    spg_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .o_push    (q_push),
        .o_item    (q_in),
        .i_q_full  (q_full),
        .o_sweep   (sweep_ctl),
        .i_sweep   (sweep_stat),
        .o_ones    (ones)
    );

    // Decoupling queue.
    spg_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    // Back end: pool memory pipeline and output register.
    spg_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_pop     (q_pop),
        .i_sweep   (sweep_ctl),
        .o_sweep   (sweep_stat),
        .i_ones    (ones),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

    // No request is taken while the pool is being swept.
    `SPG_ASSERT_IMP(a_sweep_blocks_input, i_clk, i_rst_n, sweep_stat.active, !s_axis_tready, "request accepted during sweep")
    // The sweep only runs with the queue drained.
    `SPG_ASSERT_IMP(a_sweep_queue_empty, i_clk, i_rst_n, sweep_stat.active, !q_valid, "queue holds requests during sweep")
    // A finished sweep does not retrigger.
    `SPG_ASSERT_NXT(a_sweep_no_restart, i_clk, i_rst_n, sweep_stat.done, !sweep_stat.active, "sweep restarted after completion")
    // A rejected draw carries no element and no round end.
    `SPG_ASSERT_IMP(a_range_err_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[USER_RANGE_ERR], (m_axis_tdata == '0) && !m_axis_tlast && !m_axis_tuser[USER_IS_ONE], "range error with payload")

endmodule

`default_nettype wire
